// ===== hw/rtl/frame_diff_open_filter_assert.svh =====
// assertion macros shared by the filter rtl
`ifndef FRAME_DIFF_OPEN_FILTER_ASSERT_SVH
`define FRAME_DIFF_OPEN_FILTER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define FDOF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDOF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fdof_pkg.sv =====
`default_nettype none
package fdof_pkg;

    localparam int FDOF_MAX_WIDTH = 1024;

    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int IDX_W = 2;
    localparam int FW_W  = 11;
    localparam int FH_W  = 12;
    // rows keep counting a few lines past the frame while the cascade drains
    localparam int ROW_W = 13;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 12'd480;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // which neighbours of the window centre lie inside the frame
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr_mask;

endpackage
`default_nettype wire

// ===== hw/rtl/fdof_ram.sv =====
`default_nettype none
module fdof_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = fdof_pkg::FDOF_MAX_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== hw/rtl/fdof_pos.sv =====
`default_nettype none
module fdof_pos #(
    parameter int MAX_WIDTH = fdof_pkg::FDOF_MAX_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_clear,
    input  wire logic                             i_adv,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   i_width,
    output      logic [fdof_pkg::ROW_W-1:0]       o_row,
    output      logic [$clog2(MAX_WIDTH)-1:0]     o_col,
    output      logic [$clog2(MAX_WIDTH)-1:0]     o_col_nxt
);
    import fdof_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    r_col, n_col;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_clear) begin
            n_row = '0;
            n_col = '0;
        end else if (i_adv) begin
            if (WW'(r_col) == i_width - WW'(1)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_row     = r_row;
    assign o_col     = r_col;
    assign o_col_nxt = n_col;
endmodule
`default_nettype wire

// ===== hw/rtl/fdof_stage.sv =====
`default_nettype none
module fdof_stage #(
    parameter int MAX_WIDTH = fdof_pkg::FDOF_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic                         i_dilate,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_raddr,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_waddr,
    input  wire logic                         i_bit,
    input  wire fdof_pkg::t_nbr_mask          i_mask,
    output      logic                         o_bit
);
    import fdof_pkg::*;

    // per column: [1] two rows up, [0] one row up
    logic [1:0] ram_q;
    logic [1:0] line_q;
    logic       r_byp_vld;
    logic [1:0] r_byp_dat;
    logic [1:0] wr_dat;
    // window columns: [2] top, [1] middle, [0] bottom
    logic [2:0] r_win_l, r_win_m;
    logic [2:0] win_r;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [2:0] cols [3];
    logic       acc;

    assign wr_dat = {line_q[0], i_bit};

    fdof_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_step),
        .i_waddr (i_waddr),
        .i_wdata (wr_dat),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    // one-pixel rows read the column just written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else begin
            r_byp_vld <= i_step && (i_waddr == i_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_dat <= wr_dat;
        if (i_step) begin
            r_win_l <= r_win_m;
            r_win_m <= win_r;
        end
    end

    assign line_q = r_byp_vld ? r_byp_dat : ram_q;
    assign win_r  = {line_q[1], line_q[0], i_bit};
    assign row_ok = {i_mask.up, 1'b1, i_mask.down};
    assign col_ok = {i_mask.left, 1'b1, i_mask.right};
    assign cols[0] = r_win_l;
    assign cols[1] = r_win_m;
    assign cols[2] = win_r;

    always_comb begin
        acc = !i_dilate;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (col_ok[2-c] && row_ok[r]) begin
                    if (i_dilate) begin
                        acc = acc | cols[c][r];
                    end else begin
                        acc = acc & cols[c][r];
                    end
                end
            end
        end
    end

    assign o_bit = acc;
endmodule
`default_nettype wire

// ===== hw/rtl/frame_diff_open_filter.sv =====
// Change mask of two frames: pixel pairs are XORed to one bit and cleaned by a
// 3x3 erode, erode, dilate cascade, results 0 or 255 in raster order. One
// transaction is taken per clock while the output register is free or being
// read; each pixel or flushing drain moves every started window stage by one
// pixel, and each stage has a line buffer of MAX_WIDTH two-bit words in a RAM
// with one write and one registered read port. A result leaves three rows
// plus three pixels after its pixel pair, so after the last pair of a frame
// that many drain transactions flush the rest; frame_last marks the final
// result, and the next transaction starts a new frame. A drain sent while
// pixels are still expected is taken and ignored. A write to either size
// register restarts the frame; a write to any other index does nothing. The
// output register stalls only while the downstream side holds ready low.
`default_nettype none
`include "frame_diff_open_filter_assert.svh"
module frame_diff_open_filter #(
    parameter int MAX_WIDTH = fdof_pkg::FDOF_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [fdof_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [fdof_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                         i_valid,
    output      logic                         o_ready,
    input  wire logic                         i_command,
    input  wire logic [fdof_pkg::PIX_W-1:0]   i_pixel_a,
    input  wire logic [fdof_pkg::PIX_W-1:0]   i_pixel_b,
    output      logic                         o_valid,
    input  wire logic                         i_ready,
    output      logic [fdof_pkg::PIX_W-1:0]   o_result_pixel,
    output      logic                         o_frame_last
);
    import fdof_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);

    logic [FW_W-1:0]  r_width;
    logic [FH_W-1:0]  r_height;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    logic             in_acc, in_range, step, emit, last, clear;
    logic [2:0]       r_started;
    logic [3:0]       run;
    logic [3:0]       adv;
    logic [ROW_W-1:0] row [4];
    logic [CW-1:0]    col [4];
    logic [CW-1:0]    col_nxt [4];
    t_nbr_mask        mask [3];
    logic [3:0]       bits;
    logic             r_out_valid, r_out_bit, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_FRAME_WIDTH;
            r_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
    end

    assign h_eff = (r_height == '0) ? ROW_W'(1) : ROW_W'(r_height);

    assign o_ready  = !r_out_valid || i_ready;
    assign in_acc   = i_valid && o_ready;
    assign in_range = row[0] < h_eff;
    assign step     = in_acc && !(i_command == CMD_DRAIN && in_range);
    assign emit     = step && r_started[2] && (row[3] < h_eff);
    assign last     = (row[3] == h_eff - ROW_W'(1)) && (WW'(col[3]) == w_eff - WW'(1));
    assign clear    = (i_cfg_we && (i_cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT}))
                      || (emit && last);

    assign run = {r_started, 1'b1};
    assign adv = run & {4{step}};

    // a stage starts once its feeder has passed one row plus one pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= '0;
        end else if (clear) begin
            r_started <= '0;
        end else if (step) begin
            for (int k = 0; k < 3; k++) begin
                if (run[k] && row[k] == ROW_W'(1) && col[k] == '0) begin
                    r_started[k] <= 1'b1;
                end
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_pos
        fdof_pos #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_pos (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (clear),
            .i_adv     (adv[j]),
            .i_width   (w_eff),
            .o_row     (row[j]),
            .o_col     (col[j]),
            .o_col_nxt (col_nxt[j])
        );
    end

    assign bits[0] = (i_pixel_a ^ i_pixel_b) != '0;

    for (genvar k = 0; k < 3; k++) begin : g_stage
        assign mask[k].up    = row[k+1] != '0;
        assign mask[k].down  = row[k+1] + ROW_W'(1) < h_eff;
        assign mask[k].left  = col[k+1] != '0;
        assign mask[k].right = WW'(col[k+1]) != w_eff - WW'(1);

        fdof_stage #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (adv[k]),
            .i_dilate (k == 2),
            .i_raddr  (col_nxt[k]),
            .i_waddr  (col[k]),
            .i_bit    (bits[k]),
            .i_mask   (mask[k]),
            .o_bit    (bits[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_bit  <= bits[3];
            r_out_last <= last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_pixel = {PIX_W{r_out_bit}};
    assign o_frame_last   = r_out_last;

    `FDOF_ASSERT_IMP(a_started_order, r_started[2], r_started[1] && r_started[0], "stage order broken")
    `FDOF_ASSERT_NXT(a_last_restart, emit && last, (r_started == '0) && (row[0] == '0), "no restart")
    `FDOF_ASSERT_IMP(a_stall_full, !o_ready, o_valid, "input stalled with empty output")
    `FDOF_ASSERT_IMP(a_col_range, 1'b1, WW'(col[3]) < w_eff, "column past frame width")
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import fdof_pkg::*;

    localparam int MAXW       = FDOF_MAX_WIDTH;
    localparam int RING       = 2 * MAXW + 4;
    localparam int LIMIT      = 600000;
    localparam int RAND_ITEMS = 1230;

    // indexes with no register behind them
    localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_mask_px;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic             i_command = CMD_PIXEL;
    logic [PIX_W-1:0] i_pixel_a = '0;
    logic [PIX_W-1:0] i_pixel_b = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [PIX_W-1:0] o_result_pixel;
    logic             o_frame_last;

    frame_diff_open_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_pixel_a(i_pixel_a), .i_pixel_b(i_pixel_b),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_pixel(o_result_pixel), .o_frame_last(o_frame_last)
    );

    // own copy of the filter state
    logic [FW_W-1:0] cur_width;
    logic [FH_W-1:0] cur_height;
    int unsigned     frame_pos;
    bit              stage_ring [3][RING];

    t_mask_px mask_q[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       snd_idle = 0;
    int       rcv_idle = 0;
    int       hold_off = 0;
    int       rand_sent = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_ready  <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    function automatic int unsigned eff_w();
        if (cur_width == 0) return 1;
        if (cur_width > MAXW) return MAXW;
        return cur_width;
    endfunction

    function automatic int unsigned eff_h();
        return (cur_height == 0) ? 1 : cur_height;
    endfunction

    function automatic bit window_at(int s, int unsigned q, int unsigned w,
                                     int unsigned h, bit dil);
        int r;
        int c;
        int rr;
        int cc;
        bit v;
        r = q / w;
        c = q % w;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
                    v = stage_ring[s][(rr * w + cc) % RING];
                    if (dil && v) return 1'b1;
                    if (!dil && !v) return 1'b0;
                end
            end
        end
        return !dil;
    endfunction

    // advance the cascade by one accepted transaction
    function automatic void predict_mask(logic cmd, logic [PIX_W-1:0] a,
                                         logic [PIX_W-1:0] b);
        int unsigned w;
        int unsigned total;
        int unsigned lag;
        int unsigned n;
        t_mask_px px;
        w     = eff_w();
        total = w * eff_h();
        lag   = w + 1;
        n     = frame_pos;
        if (n < total) begin
            if (cmd == CMD_DRAIN) return;
            stage_ring[0][n % RING] = ((a ^ b) != 0);
        end
        if (n >= lag && n - lag < total)
            stage_ring[1][(n - lag) % RING] = window_at(0, n - lag, w, eff_h(), 1'b0);
        if (n >= 2 * lag && n - 2 * lag < total)
            stage_ring[2][(n - 2 * lag) % RING] =
                window_at(1, n - 2 * lag, w, eff_h(), 1'b0);
        if (n >= 3 * lag && n - 3 * lag < total) begin
            px.pixel = window_at(2, n - 3 * lag, w, eff_h(), 1'b1) ? 8'd255 : 8'd0;
            px.last  = (n - 3 * lag == total - 1);
            mask_q.push_back(px);
            frame_pos = px.last ? 0 : n + 1;
            return;
        end
        frame_pos = n + 1;
    endfunction

    // result check, sampled mid-cycle so the edge ordering never matters
    always @(negedge i_clk) begin
        t_mask_px px;
        if (i_rst_n && o_valid && i_ready) begin
            if (mask_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d last %0b", o_result_pixel, o_frame_last);
            end else begin
                px = mask_q.pop_front();
                if (o_result_pixel !== px.pixel || o_frame_last !== px.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                 px.pixel, px.last, o_result_pixel, o_frame_last);
                end
            end
        end
    end

    task automatic send_item(logic cmd, logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        bit hit;
        if ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_pixel_a <= a;
        i_pixel_b <= b;
        do begin
            @(negedge i_clk);
            hit = o_ready;
            @(posedge i_clk);
        end while (!hit);
        predict_mask(cmd, a, b);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        wait (mask_q.size() == 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH) begin
            cur_width = data[FW_W-1:0];
            frame_pos = 0;
        end else if (idx == REG_FRAME_HEIGHT) begin
            cur_height = data[FH_W-1:0];
            frame_pos = 0;
        end
    endtask

    task automatic set_size(int wv, int hv);
        write_reg(REG_FRAME_WIDTH, CFG_W'(wv));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(hv));
    endtask

    // part of a frame with random pairs, left unfinished
    task automatic send_partial(int count);
        for (int i = 0; i < count; i++)
            send_item(CMD_PIXEL, PIX_W'($urandom), PIX_W'($urandom));
    endtask

    // one full frame; density steers how many pairs differ, noise adds
    // ignored early drains and surplus pixels in the flush
    task automatic run_frame(int density, bit noise);
        int unsigned total;
        int unsigned flush;
        logic [PIX_W-1:0] a;
        total = eff_w() * eff_h();
        flush = 3 * (eff_w() + 1);
        for (int unsigned i = 0; i < total; i++) begin
            if (noise && $urandom_range(99) < 3)
                send_item(CMD_DRAIN, PIX_W'($urandom), PIX_W'($urandom));
            a = PIX_W'($urandom);
            if ($urandom_range(99) < density)
                send_item(CMD_PIXEL, a, a ^ (8'd1 << $urandom_range(7)) ^
                          ($urandom_range(1) ? 8'($urandom) & 8'hfe : 8'd0));
            else
                send_item(CMD_PIXEL, a, a);
            rand_sent++;
        end
        for (int unsigned i = 0; i < flush; i++) begin
            if (noise && $urandom_range(99) < 20)
                send_item(CMD_PIXEL, PIX_W'($urandom), PIX_W'($urandom));
            else
                send_item(CMD_DRAIN, PIX_W'($urandom), PIX_W'($urandom));
            rand_sent++;
        end
    endtask

    task automatic test_directed();
        set_size(3, 3);
        send_item(CMD_PIXEL, 8'd0, 8'd255);
        send_item(CMD_PIXEL, 8'd255, 8'd0);
        send_item(CMD_DRAIN, 8'd0, 8'd0);   // early drain, ignored
        send_item(CMD_PIXEL, 8'd255, 8'd255);
        send_item(CMD_PIXEL, 8'd0, 8'd0);
        for (int i = 0; i < 5; i++) send_item(CMD_PIXEL, 8'h5a, 8'ha5);
        for (int i = 0; i < 12; i++)
            send_item(i[0] ? CMD_PIXEL : CMD_DRAIN, 8'd255, 8'd0);
        wait_drained();
        set_size(0, 0);                     // acts as a single pixel
        run_frame(100, 1'b0);
        wait_drained();
        set_size(4, 4);
        run_frame(100, 1'b0);               // all set survives the cascade
        wait_drained();
        write_reg(REG_SPARE_A, 12'd7);      // unknown registers
        write_reg(REG_SPARE_B, 12'hfff);
        run_frame(60, 1'b1);
        wait_drained();
    endtask

    task automatic test_extreme_sizes();
        set_size(2047, 1);                  // clamps to the maximum width
        send_partial(100);
        wait_drained();
        set_size(MAXW, 2);
        send_partial(100);
        wait_drained();
        set_size(1, 4095);
        send_partial(200);
        wait_drained();
    endtask

    task automatic test_restart();
        set_size(6, 5);
        for (int i = 0; i < 40; i++)
            send_item(CMD_PIXEL, PIX_W'($urandom), PIX_W'($urandom));
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, 12'd4);
        run_frame(85, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_size(8, 8);
        hold_off = 300;
        run_frame(90, 1'b0);
        wait_drained();
    endtask

    task automatic test_random(int s_idle, int r_idle, int quota);
        int goal;
        snd_idle = s_idle;
        rcv_idle = r_idle;
        goal = rand_sent + quota;
        while (rand_sent < goal) begin
            if ($urandom_range(19) == 0)
                set_size($urandom_range(40, 1), $urandom_range(12, 1));
            else
                set_size($urandom_range(12, 1), $urandom_range(8, 1));
            run_frame($urandom_range(99, 60), $urandom_range(3) == 0);
            wait_drained();
        end
    endtask

    initial begin
        cur_width  = RST_FRAME_WIDTH;
        cur_height = RST_FRAME_HEIGHT;
        frame_pos  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        snd_idle = 10;
        rcv_idle = 57;
        test_directed();
        test_restart();
        test_backpressure();
        test_extreme_sizes();
        rand_sent = 0;
        test_random(10, 57, RAND_ITEMS / 3);
        test_random(57, 10, RAND_ITEMS / 3);
        test_random(0, 0, RAND_ITEMS / 3);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && mask_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
